@@ hw/rtl/gssa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gssa_pkg;

  localparam int unsigned ADDR_W         = 64;
  localparam int unsigned SIZE_W         = 32;
  localparam int unsigned MODE_W         = 2;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned INDEX_W        = 6;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 64;
  // Usage map is kept as rows of ROW_W slots, ROW_W == 2**ROW_BW
  localparam int unsigned ROW_W          = 8;
  localparam int unsigned ROW_BW         = 3;
  localparam int unsigned SLOT_COUNT_DEF = 64;

  localparam logic [ADDR_W-1:0] AREA_BASE_RST  = '0;
  localparam logic [SIZE_W-1:0] SLOT_SIZE_RST  = 32'd20480;
  localparam logic [SIZE_W-1:0] GUARD_SIZE_RST = 32'd4096;
  localparam logic [SIZE_W-1:0] STACK_SIZE_RST = 32'd16384;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_GUARD = 2'd2
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BAD    = 2'd2,
    ST_UNUSED = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AREA_BASE  = 2'd0,
    REG_SLOT_SIZE  = 2'd1,
    REG_GUARD_SIZE = 2'd2,
    REG_STACK_SIZE = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    RD_PTR      = 2'd0,
    RD_PTR_NEXT = 2'd1,
    RD_SLOT     = 2'd2
  } rd_sel_e;

  typedef enum logic {
    MUL_SPAN = 1'b0,
    MUL_SLOT = 1'b1
  } mul_sel_e;

  typedef enum logic [1:0] {
    ADD_BASE  = 2'd0,
    ADD_GUARD = 2'd1,
    ADD_TOP   = 2'd2
  } add_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ALLOC_SCAN,
    S_ALLOC_MUL,
    S_ALLOC_BASE,
    S_ALLOC_GUARD,
    S_ALLOC_TOP,
    S_RANGE,
    S_DIV,
    S_DIV_DONE,
    S_FREE_RD,
    S_FREE_CHK,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic     load;
    rd_sel_e  rd_sel;
    logic     ptr_inc;
    logic     scan_take;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     add_en;
    add_sel_e add_sel;
    logic     off_en;
    logic     div_load;
    logic     div_step;
    logic     guard_eval;
    logic     slot_from_quo;
    logic     free_clear;
    logic     set_status;
    status_e  status;
    logic     set_idx;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              scan_hit;
    logic              scan_last;
    logic              in_area;
    logic              ge_guard;
    logic              div_last;
    logic              rem_zero;
    logic              slot_ok;
    logic              bit_used;
    logic              out_busy;
  } stat_t;

  function automatic int unsigned addr_w(int unsigned n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/gssa_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface gssa_in_if;
  import gssa_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ADDR_W-1:0] address;
  modport source (output valid, output mode, output address, input ready);
  modport sink (input valid, input mode, input address, output ready);
endinterface

interface gssa_out_if;
  import gssa_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   stack_base;
  logic [ADDR_W-1:0]   stack_top;
  logic [INDEX_W-1:0]  slot_index;
  logic                is_guard;
  modport source (output valid, output status, output stack_base, output stack_top,
                  output slot_index, output is_guard, input ready);
  modport sink (input valid, input status, input stack_base, input stack_top,
                input slot_index, input is_guard, output ready);
endinterface

interface gssa_cfg_if;
  import gssa_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/gssa_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gssa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [gssa_pkg::addr_w(DEPTH)-1:0]   waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic [gssa_pkg::addr_w(DEPTH)-1:0]   raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/gssa_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gssa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  gssa_pkg::stat_t stat_i,
  output gssa_pkg::cmd_t  cmd_o
);
  import gssa_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        // offset and area span are worked out for every mode; row 0 is fetched
        cmd_o.off_en  = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_SPAN;
        cmd_o.rd_sel  = RD_PTR;
        if (stat_i.mode == MODE_ALLOC) begin
          state_d = S_ALLOC_SCAN;
        end else if (stat_i.mode == MODE_FREE || stat_i.mode == MODE_GUARD) begin
          state_d = S_RANGE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_ALLOC_SCAN: begin
        cmd_o.rd_sel = RD_PTR_NEXT;
        if (stat_i.scan_hit) begin
          cmd_o.scan_take = 1'b1;
          state_d         = S_ALLOC_MUL;
        end else if (stat_i.scan_last) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_FULL;
          state_d          = S_DONE;
        end else begin
          cmd_o.ptr_inc = 1'b1;
        end
      end
      S_ALLOC_MUL: begin
        cmd_o.mul_en     = 1'b1;
        cmd_o.mul_sel    = MUL_SLOT;
        cmd_o.set_status = 1'b1;
        cmd_o.status     = ST_OK;
        cmd_o.set_idx    = 1'b1;
        state_d          = S_ALLOC_BASE;
      end
      S_ALLOC_BASE: begin
        cmd_o.add_en  = 1'b1;
        cmd_o.add_sel = ADD_BASE;
        state_d       = S_ALLOC_GUARD;
      end
      S_ALLOC_GUARD: begin
        cmd_o.add_en  = 1'b1;
        cmd_o.add_sel = ADD_GUARD;
        state_d       = S_ALLOC_TOP;
      end
      S_ALLOC_TOP: begin
        cmd_o.add_en  = 1'b1;
        cmd_o.add_sel = ADD_TOP;
        state_d       = S_DONE;
      end
      S_RANGE: begin
        if (stat_i.mode == MODE_GUARD) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_OK;
          if (stat_i.in_area) begin
            cmd_o.div_load = 1'b1;
            state_d        = S_DIV;
          end else begin
            state_d = S_DONE;
          end
        end else if (stat_i.in_area && stat_i.ge_guard) begin
          cmd_o.div_load = 1'b1;
          state_d        = S_DIV;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = S_DIV_DONE;
        end
      end
      S_DIV_DONE: begin
        if (stat_i.mode == MODE_GUARD) begin
          cmd_o.guard_eval = 1'b1;
          state_d          = S_DONE;
        end else if (stat_i.rem_zero) begin
          cmd_o.slot_from_quo = 1'b1;
          state_d             = S_FREE_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_FREE_RD: begin
        cmd_o.rd_sel = RD_SLOT;
        state_d      = stat_i.slot_ok ? S_FREE_CHK : S_DONE;
      end
      S_FREE_CHK: begin
        cmd_o.set_idx    = 1'b1;
        cmd_o.set_status = 1'b1;
        cmd_o.status     = stat_i.bit_used ? ST_OK : ST_UNUSED;
        cmd_o.free_clear = stat_i.bit_used;
        state_d          = S_DONE;
      end
      S_DONE: begin
        // hold until the output register can take the word
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/gssa_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gssa_datapath #(
  parameter int unsigned SLOT_COUNT = gssa_pkg::SLOT_COUNT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gssa_pkg::cmd_t                    cmd_i,
  output gssa_pkg::stat_t                   stat_o,
  input  logic                              cfg_we_i,
  input  logic [gssa_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [gssa_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [gssa_pkg::MODE_W-1:0]       mode_i,
  input  logic [gssa_pkg::ADDR_W-1:0]       address_i,
  gssa_out_if.source                        result_o
);
  import gssa_pkg::*;

  localparam int unsigned ROWS   = (SLOT_COUNT + ROW_W - 1) / ROW_W;
  localparam int unsigned ROW_AW = addr_w(ROWS);
  localparam int unsigned SN_W   = ROW_AW + ROW_BW;
  localparam int unsigned MA_W   = SN_W + 1;
  localparam int unsigned PW     = MA_W + SIZE_W;
  localparam int unsigned QW     = addr_w(SLOT_COUNT);
  localparam int unsigned DV_W   = SIZE_W + QW;
  localparam int unsigned CW     = addr_w(QW);

  // configuration
  logic [ADDR_W-1:0] area_base_q;
  logic [SIZE_W-1:0] slot_size_q, guard_size_q, stack_size_q;

  // item and working registers
  logic [MODE_W-1:0] mode_q;
  logic [ADDR_W-1:0] addr_q;
  logic [ROW_AW-1:0] ptr_q;
  logic [SN_W-1:0]   slot_q;
  logic [PW-1:0]     prod_q;
  logic [ADDR_W-1:0] acc_q;
  logic [ADDR_W-1:0] off_q;
  logic              borrow_q;
  logic [DV_W-1:0]   rem_q, dvs_q;
  logic [QW-1:0]     quo_q;
  logic [CW-1:0]     cnt_q;

  // result and output registers
  status_e            res_status_q;
  logic [ADDR_W-1:0]  res_base_q, res_top_q;
  logic [INDEX_W-1:0] res_idx_q;
  logic               res_guard_q;
  logic               out_valid_q;
  status_e            out_status_q;
  logic [ADDR_W-1:0]  out_base_q, out_top_q;
  logic [INDEX_W-1:0] out_idx_q;
  logic               out_guard_q;

  // usage map
  logic [ROWS-1:0]   row_valid_q;
  logic              row_ok_q;
  logic [ROW_AW-1:0] rd_addr, wr_addr;
  logic [ROW_W-1:0]  ram_rdata, row_raw, row_eff, pad, wr_data;
  logic [ROW_BW-1:0] free_bit;
  logic              wr_en;

  // arithmetic
  logic [ADDR_W:0]         off_full;
  logic [ADDR_W-1:0]       rel, add_a, add_b, add_sum;
  logic [MA_W-1:0]         mul_a;
  logic [PW-1:0]           prod_d;
  logic [DV_W-1:0]         dividend, dvs_init, guard_lim;
  logic                    rem_ge, is_guard_d;
  logic [INDEX_W+SN_W-1:0] idx_ext;

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_PTR:      rd_addr = ptr_q;
      RD_PTR_NEXT: rd_addr = ptr_q + 1'b1;
      RD_SLOT:     rd_addr = slot_q[SN_W-1:ROW_BW];
      default:     rd_addr = ptr_q;
    endcase
  end

  assign row_raw = row_ok_q ? ram_rdata : '0;

  // slots past the end of the area read as taken
  always_comb begin
    for (int b = 0; b < ROW_W; b++) begin
      pad[b] = {1'b0, ptr_q, ROW_BW'(b)} >= (SN_W + 1)'(SLOT_COUNT);
    end
  end

  assign row_eff = row_raw | pad;

  always_comb begin
    free_bit = '0;
    for (int b = ROW_W - 1; b >= 0; b--) begin
      if (!row_eff[b]) begin
        free_bit = ROW_BW'(b);
      end
    end
  end

  assign wr_en   = cmd_i.scan_take | cmd_i.free_clear;
  assign wr_addr = cmd_i.scan_take ? ptr_q : slot_q[SN_W-1:ROW_BW];
  assign wr_data = cmd_i.scan_take ? (row_raw | (ROW_W'(1) << free_bit))
                                   : (row_raw & ~(ROW_W'(1) << slot_q[ROW_BW-1:0]));

  gssa_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  assign off_full = {1'b0, addr_q} - {1'b0, area_base_q};
  assign rel      = off_q - ADDR_W'(guard_size_q);
  // offset is below the span here, so it fits the divider width
  assign dividend = (mode_q == MODE_FREE) ? rel[DV_W-1:0] : off_q[DV_W-1:0];
  assign dvs_init = DV_W'(slot_size_q) << (QW - 1);
  assign rem_ge   = rem_q >= dvs_q;

  assign guard_lim  = DV_W'(guard_size_q) + DV_W'(stack_size_q);
  assign is_guard_d = (rem_q < DV_W'(guard_size_q)) || (rem_q >= guard_lim);

  assign mul_a  = (cmd_i.mul_sel == MUL_SPAN) ? MA_W'(SLOT_COUNT) : {1'b0, slot_q};
  assign prod_d = PW'(mul_a) * PW'(slot_size_q);

  always_comb begin
    unique case (cmd_i.add_sel)
      ADD_BASE: begin
        add_a = area_base_q;
        add_b = ADDR_W'(prod_q);
      end
      ADD_GUARD: begin
        add_a = acc_q;
        add_b = ADDR_W'(guard_size_q);
      end
      ADD_TOP: begin
        add_a = acc_q;
        add_b = ADDR_W'(stack_size_q);
      end
      default: begin
        add_a = acc_q;
        add_b = '0;
      end
    endcase
  end

  assign add_sum = add_a + add_b;
  assign idx_ext = {{INDEX_W{1'b0}}, slot_q};

  assign stat_o.mode      = mode_q;
  assign stat_o.scan_hit  = ~&row_eff;
  assign stat_o.scan_last = ptr_q == ROW_AW'(ROWS - 1);
  assign stat_o.in_area   = !borrow_q && (off_q < ADDR_W'(prod_q));
  assign stat_o.ge_guard  = off_q >= ADDR_W'(guard_size_q);
  assign stat_o.div_last  = cnt_q == '0;
  assign stat_o.rem_zero  = rem_q == '0;
  assign stat_o.slot_ok   = {1'b0, slot_q} < (SN_W + 1)'(SLOT_COUNT);
  assign stat_o.bit_used  = row_raw[slot_q[ROW_BW-1:0]];
  assign stat_o.out_busy  = out_valid_q && !result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_base_q  <= AREA_BASE_RST;
      slot_size_q  <= SLOT_SIZE_RST;
      guard_size_q <= GUARD_SIZE_RST;
      stack_size_q <= STACK_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_AREA_BASE:  area_base_q  <= cfg_data_i;
        REG_SLOT_SIZE:  slot_size_q  <= cfg_data_i[SIZE_W-1:0];
        REG_GUARD_SIZE: guard_size_q <= cfg_data_i[SIZE_W-1:0];
        REG_STACK_SIZE: stack_size_q <= cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    row_ok_q <= row_valid_q[rd_addr];
    if (cmd_i.load) begin
      mode_q       <= mode_i;
      addr_q       <= address_i;
      ptr_q        <= '0;
      res_status_q <= ST_BAD;
      res_base_q   <= '0;
      res_top_q    <= '0;
      res_idx_q    <= '0;
      res_guard_q  <= 1'b0;
    end
    if (cmd_i.ptr_inc) begin
      ptr_q <= ptr_q + 1'b1;
    end
    if (cmd_i.scan_take) begin
      slot_q <= {ptr_q, free_bit};
    end
    if (cmd_i.slot_from_quo) begin
      slot_q <= SN_W'(quo_q);
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.off_en) begin
      off_q    <= off_full[ADDR_W-1:0];
      borrow_q <= off_full[ADDR_W];
    end
    if (cmd_i.add_en) begin
      acc_q <= add_sum;
      if (cmd_i.add_sel == ADD_GUARD) begin
        res_base_q <= add_sum;
      end
      if (cmd_i.add_sel == ADD_TOP) begin
        res_top_q <= add_sum;
      end
    end
    // restoring divide, one quotient bit a cycle, msb first
    if (cmd_i.div_load) begin
      rem_q <= dividend;
      dvs_q <= dvs_init;
      quo_q <= '0;
      cnt_q <= CW'(QW - 1);
    end else if (cmd_i.div_step) begin
      if (rem_ge) begin
        rem_q <= rem_q - dvs_q;
      end
      quo_q <= (quo_q << 1) | QW'(rem_ge);
      dvs_q <= dvs_q >> 1;
      cnt_q <= cnt_q - 1'b1;
    end
    if (cmd_i.guard_eval) begin
      res_guard_q <= is_guard_d;
    end
    if (cmd_i.set_status) begin
      res_status_q <= cmd_i.status;
    end
    if (cmd_i.set_idx) begin
      res_idx_q <= idx_ext[INDEX_W-1:0];
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_base_q   <= res_base_q;
      out_top_q    <= res_top_q;
      out_idx_q    <= res_idx_q;
      out_guard_q  <= res_guard_q;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.status     = out_status_q;
  assign result_o.stack_base = out_base_q;
  assign result_o.stack_top  = out_top_q;
  assign result_o.slot_index = out_idx_q;
  assign result_o.is_guard   = out_guard_q;

endmodule

`default_nettype wire

@@ hw/rtl/guarded_stack_slot_allocator_core.sv @@
// Guarded stack slot allocator: hands out the lowest free slot of a fixed area of
// SLOT_COUNT slots (guard, then stack, then slack) and returns its stack base and
// top, frees a slot given its stack base, and answers whether an address lies in
// a guard or slack region. One word in gives one word out; items are handled one
// at a time, and a new item is taken while the previous result still waits on the
// output register. The usage map lives in a RAM of 8-slot rows with one valid bit
// per row, so reset needs no clearing pass. The first-fit scan of an allocate reads
// 1 to ceil(SLOT_COUNT/8) rows, one row per cycle from the RAM port. Free and guard
// queries use a bit-serial divider that splits the area offset into slot number and
// offset within the slot. Bad or out-of-area addresses finish early. Configuration
// writes are always accepted and must be made while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module guarded_stack_slot_allocator_core #(
  parameter int unsigned SLOT_COUNT = gssa_pkg::SLOT_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gssa_cfg_if.sink    cfg_i,
  gssa_in_if.sink     item_i,
  gssa_out_if.source  result_o
);
  import gssa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_i.ready = 1'b1;

  gssa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gssa_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .cfg_we_i   (cfg_i.valid),
    .cfg_idx_i  (cfg_i.index),
    .cfg_data_i (cfg_i.data),
    .mode_i     (item_i.mode),
    .address_i  (item_i.address),
    .result_o   (result_o)
  );

  a_load_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !stat.out_busy)
    else $error("result word loaded over an undelivered word");

  a_one_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready) |=> !item_i.ready)
    else $error("second item taken while one is in progress");

  a_full_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.status == ST_FULL) |->
      (result_o.stack_base == '0 && result_o.stack_top == '0 && result_o.slot_index == '0))
    else $error("full status with nonzero address fields");

  a_guard_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.is_guard) |-> result_o.status == ST_OK)
    else $error("guard flag set on a failed word");

endmodule

`default_nettype wire
